/* hdl/stl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_pkg
// Types, codes and scan functions shared by the source text lexer modules.
// ----------------------------------------------------------------------------
package stl_pkg;

    // Scan modes; the punctuation kinds double as modes that wait to close.
    localparam logic [4:0] M_IDLE    = 5'd0;
    localparam logic [4:0] M_NAME    = 5'd1;
    localparam logic [4:0] M_SYM     = 5'd2;
    localparam logic [4:0] M_ZERO    = 5'd3;
    localparam logic [4:0] M_HEX0    = 5'd4;
    localparam logic [4:0] M_HEX     = 5'd5;
    localparam logic [4:0] M_BIN0    = 5'd6;
    localparam logic [4:0] M_BIN     = 5'd7;
    localparam logic [4:0] M_DEC     = 5'd8;
    localparam logic [4:0] M_DOT     = 5'd20;
    localparam logic [4:0] M_FRAC    = 5'd21;
    localparam logic [4:0] M_STR     = 5'd22;
    localparam logic [4:0] M_OP      = 5'd23;
    localparam logic [4:0] M_INVALID = 5'd24;
    localparam logic [4:0] M_MINUS   = 5'd25;
    localparam logic [4:0] M_COLON   = 5'd26;
    localparam logic [4:0] M_HASH    = 5'd27;

    // Token kinds.
    localparam logic [4:0] K_END     = 5'd0;
    localparam logic [4:0] K_NAME    = 5'd1;
    localparam logic [4:0] K_CNAME   = 5'd2;
    localparam logic [4:0] K_INT     = 5'd3;
    localparam logic [4:0] K_HEX     = 5'd4;
    localparam logic [4:0] K_BIN     = 5'd5;
    localparam logic [4:0] K_FLOAT   = 5'd6;
    localparam logic [4:0] K_STRING  = 5'd7;
    localparam logic [4:0] K_SYMBOL  = 5'd8;
    localparam logic [4:0] K_ASSIGN  = 5'd9;
    localparam logic [4:0] K_COLON   = 5'd10;
    localparam logic [4:0] K_SEMI    = 5'd11;
    localparam logic [4:0] K_CARET   = 5'd12;
    localparam logic [4:0] K_DOT     = 5'd13;
    localparam logic [4:0] K_LPAREN  = 5'd14;
    localparam logic [4:0] K_RPAREN  = 5'd15;
    localparam logic [4:0] K_LBRACK  = 5'd16;
    localparam logic [4:0] K_RBRACK  = 5'd17;
    localparam logic [4:0] K_LBRACE  = 5'd18;
    localparam logic [4:0] K_RBRACE  = 5'd19;
    localparam logic [4:0] K_OPER    = 5'd20;
    localparam logic [4:0] K_SEP     = 5'd21;
    localparam logic [4:0] K_INVALID = 5'd22;

    // Error codes.
    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_STRING  = 2'd1;
    localparam logic [1:0] E_UNDERSC = 2'd2;

    localparam logic [2:0] SEP_LEN     = 3'd5;
    localparam logic [2:0] MAX_RESULTS = 3'd4;
    localparam int         SCAN_STEPS  = 8;

    // One result: a kept character or a token end.
    typedef struct packed {
        logic [7:0]  ch;
        logic        cv;
        logic        te;
        logic [4:0]  kind;
        logic [15:0] line;
        logic [1:0]  err;
    } t_res;

    // All results caused by one input item.
    typedef struct packed {
        t_res [3:0] res;
        logic [2:0] cnt;
    } t_bundle;

    // Scanner state; the line count is carried wide and narrowed at the register.
    typedef struct packed {
        logic [4:0]  mode;
        logic [7:0]  h0;
        logic [7:0]  h1;
        logic [1:0]  hc;
        logic [31:0] line;
        logic        dash_only;
        logic [2:0]  dash_run;
        logic        pwd;
        logic        esc;
    } t_scan_st;

    typedef struct packed {
        t_scan_st st;
        t_bundle  out;
        logic     done;
    } t_scan;

    function automatic t_scan_st scan_reset();
        t_scan_st s;
        s           = '0;
        s.mode      = M_IDLE;
        s.line      = 32'd1;
        return s;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_xdigit(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_op(logic [7:0] c);
        return c inside {"+", "-", "*", "/", 8'h5c, "%", "&", "<", ">", "=", "?",
                         "|", "@", "!", ","};
    endfunction

    function automatic logic [4:0] punct_kind(logic [7:0] c);
        logic [4:0] k;
        case (c)
            ";": k = K_SEMI;
            "^": k = K_CARET;
            ".": k = K_DOT;
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "[": k = K_LBRACK;
            "]": k = K_RBRACK;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            default: k = K_END;
        endcase
        return k;
    endfunction

    // Append one result if there is room.
    function automatic t_scan put(t_scan s, logic [7:0] ch, logic cv, logic te,
                                  logic [4:0] kind, logic [1:0] err);
        t_res r;
        r.ch   = ch;
        r.cv   = cv;
        r.te   = te;
        r.kind = kind;
        r.line = te ? s.st.line[15:0] : 16'd0;
        r.err  = err;
        if (s.out.cnt < MAX_RESULTS) begin
            s.out.res[s.out.cnt[1:0]] = r;
            s.out.cnt = s.out.cnt + 3'd1;
        end
        return s;
    endfunction

    function automatic t_scan emit_char(t_scan s, logic [7:0] c);
        return put(s, c, 1'b1, 1'b0, K_END, E_NONE);
    endfunction

    function automatic t_scan emit_end(t_scan s, logic [4:0] kind, logic [1:0] err);
        t_scan v;
        v         = put(s, 8'd0, 1'b0, 1'b1, kind, err);
        v.st.mode = M_IDLE;
        return v;
    endfunction

    function automatic t_scan hold(t_scan s, logic [7:0] c);
        if (s.st.hc == 2'd0) begin
            s.st.h0 = c;
            s.st.hc = 2'd1;
        end else if (s.st.hc == 2'd1) begin
            s.st.h1 = c;
            s.st.hc = 2'd2;
        end
        return s;
    endfunction

    function automatic t_scan drop_held(t_scan s);
        s.st.hc = 2'd0;
        s.st.h0 = 8'd0;
        s.st.h1 = 8'd0;
        return s;
    endfunction

    function automatic t_scan flush_held(t_scan s);
        t_scan v;
        v = s;
        if (s.st.hc != 2'd0) begin
            v = emit_char(v, s.st.h0);
        end
        if (s.st.hc >= 2'd2) begin
            v = emit_char(v, s.st.h1);
        end
        return drop_held(v);
    endfunction

    function automatic logic [1:0] num_err(t_scan s);
        return s.st.pwd ? E_NONE : E_UNDERSC;
    endfunction

    // A byte seen between tokens.
    function automatic t_scan idle_byte(t_scan s, logic [7:0] c, logic [31:0] lim);
        t_scan      v;
        logic [4:0] k;
        v = s;
        k = punct_kind(c);
        if (c == 8'd0) begin
            v = s;
        end else if (is_space(c)) begin
            if (c == 8'h0a && v.st.line < lim) begin
                v.st.line = v.st.line + 32'd1;
            end
        end else if (is_alpha(c)) begin
            v         = emit_char(v, c);
            v.st.mode = M_NAME;
        end else if (c == "0") begin
            v         = hold(v, c);
            v.st.mode = M_ZERO;
        end else if (is_digit(c)) begin
            v         = emit_char(v, c);
            v.st.pwd  = 1'b1;
            v.st.mode = M_DEC;
        end else if (c == "-") begin
            v         = hold(v, c);
            v.st.mode = M_MINUS;
        end else if (c == ":") begin
            v         = hold(v, c);
            v.st.mode = M_COLON;
        end else if (c == "#") begin
            v         = hold(v, c);
            v.st.mode = M_HASH;
        end else if (c == 8'h27) begin
            v.st.esc  = 1'b0;
            v.st.mode = M_STR;
        end else if (k != K_END) begin
            v         = emit_char(v, c);
            v.st.mode = k;
        end else if (is_op(c)) begin
            v              = emit_char(v, c);
            v.st.dash_only = 1'b0;
            v.st.dash_run  = 3'd1;
            v.st.mode      = M_OP;
        end else begin
            v         = emit_char(v, c);
            v.st.mode = M_INVALID;
        end
        return v;
    endfunction

    // One pass of the mode logic; done is set when the byte is consumed.
    function automatic t_scan scan_byte(t_scan s, logic [7:0] c, logic [31:0] lim);
        t_scan v;
        v = s;
        case (s.st.mode)
            M_IDLE: begin
                v      = idle_byte(v, c, lim);
                v.done = 1'b1;
            end
            M_NAME: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    v      = emit_char(v, c);
                    v.done = 1'b1;
                end else if (c == ":") begin
                    v      = emit_end(emit_char(v, c), K_CNAME, E_NONE);
                    v.done = 1'b1;
                end else begin
                    v = emit_end(v, K_NAME, E_NONE);
                end
            end
            M_SYM: begin
                if (is_alpha(c)) begin
                    v      = emit_char(v, c);
                    v.done = 1'b1;
                end else begin
                    v = emit_end(v, K_SYMBOL, E_NONE);
                end
            end
            M_ZERO: begin
                if (c == "x") begin
                    v         = hold(v, c);
                    v.st.mode = M_HEX0;
                    v.done    = 1'b1;
                end else if (c == "b") begin
                    v         = hold(v, c);
                    v.st.mode = M_BIN0;
                    v.done    = 1'b1;
                end else begin
                    v         = flush_held(v);
                    v.st.pwd  = 1'b1;
                    v.st.mode = M_DEC;
                end
            end
            M_HEX0, M_BIN0: begin
                if ((s.st.mode == M_HEX0) ? is_xdigit(c) : (c == "0" || c == "1")) begin
                    v         = emit_char(drop_held(v), c);
                    v.st.mode = (s.st.mode == M_HEX0) ? M_HEX : M_BIN;
                    v.done    = 1'b1;
                end else begin
                    v = emit_end(flush_held(v), K_INVALID, E_NONE);
                end
            end
            M_HEX: begin
                if (is_xdigit(c)) begin
                    v      = emit_char(v, c);
                    v.done = 1'b1;
                end else begin
                    v = emit_end(v, K_HEX, E_NONE);
                end
            end
            M_BIN: begin
                if (c == "0" || c == "1") begin
                    v      = emit_char(v, c);
                    v.done = 1'b1;
                end else begin
                    v = emit_end(v, K_BIN, E_NONE);
                end
            end
            M_DEC: begin
                if (is_digit(c)) begin
                    v        = emit_char(v, c);
                    v.st.pwd = 1'b1;
                    v.done   = 1'b1;
                end else if (c == "_" && s.st.pwd) begin
                    v.st.pwd = 1'b0;
                    v.done   = 1'b1;
                end else if (c == ".") begin
                    v         = hold(v, c);
                    v.st.mode = M_DOT;
                    v.done    = 1'b1;
                end else begin
                    v = emit_end(v, K_INT, num_err(s));
                end
            end
            M_DOT: begin
                if (is_digit(c)) begin
                    v         = emit_char(flush_held(v), c);
                    v.st.mode = M_FRAC;
                    v.done    = 1'b1;
                end else begin
                    v = emit_end(drop_held(v), K_INT, num_err(s));
                    v = idle_byte(v, ".", lim);
                end
            end
            M_FRAC: begin
                if (is_digit(c)) begin
                    v      = emit_char(v, c);
                    v.done = 1'b1;
                end else begin
                    v = emit_end(v, K_FLOAT, num_err(s));
                end
            end
            M_STR: begin
                if (c == 8'd0) begin
                    v.st.esc = 1'b0;
                    v        = emit_end(v, K_STRING, E_STRING);
                end else if (s.st.esc) begin
                    v.st.esc = 1'b0;
                    v        = emit_char(v, c);
                    v.done   = 1'b1;
                end else if (c == 8'h27) begin
                    v      = emit_end(v, K_STRING, E_NONE);
                    v.done = 1'b1;
                end else if (c == 8'h0a) begin
                    v = emit_end(v, K_STRING, E_STRING);
                end else if (c == 8'h5c) begin
                    v.st.esc = 1'b1;
                    v.done   = 1'b1;
                end else begin
                    v      = emit_char(v, c);
                    v.done = 1'b1;
                end
            end
            M_OP: begin
                if (is_op(c)) begin
                    v = emit_char(v, c);
                    if (c != "-") begin
                        v.st.dash_only = 1'b0;
                    end
                    if (s.st.dash_run < SEP_LEN) begin
                        v.st.dash_run = s.st.dash_run + 3'd1;
                    end
                    v.done = 1'b1;
                end else begin
                    v = emit_end(v, (s.st.dash_only && s.st.dash_run >= SEP_LEN) ?
                                    K_SEP : K_OPER, E_NONE);
                    v.st.dash_only = 1'b0;
                    v.st.dash_run  = 3'd0;
                end
            end
            M_INVALID: begin
                if (c == 8'd0 || is_space(c)) begin
                    v = emit_end(v, K_INVALID, E_NONE);
                end else begin
                    v      = emit_char(v, c);
                    v.done = 1'b1;
                end
            end
            M_MINUS: begin
                v = flush_held(v);
                if (is_digit(c)) begin
                    v.st.pwd  = 1'b0;
                    v.st.mode = M_DEC;
                end else begin
                    v.st.dash_only = 1'b1;
                    v.st.dash_run  = 3'd1;
                    v.st.mode      = M_OP;
                end
            end
            M_COLON: begin
                v = flush_held(v);
                if (c == "=") begin
                    v      = emit_end(emit_char(v, c), K_ASSIGN, E_NONE);
                    v.done = 1'b1;
                end else begin
                    v.st.mode = K_COLON;
                end
            end
            M_HASH: begin
                if (is_alpha(c)) begin
                    v         = drop_held(v);
                    v.st.mode = M_SYM;
                end else begin
                    v         = flush_held(v);
                    v.st.mode = M_INVALID;
                end
            end
            default: begin
                // Single punctuation closes before the next byte is looked at.
                if (s.st.mode >= K_ASSIGN && s.st.mode <= K_RBRACE) begin
                    v = emit_end(v, s.st.mode, E_NONE);
                end
                v.st.mode = M_IDLE;
            end
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* hdl/source_text_lexer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_text_lexer_unit
// Streaming lexer: source bytes in, token characters and token ends out.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                               tuser         tlast
// s_axis    in   [7:0] text_byte                     end_of_input  -
// m_axis    out  [7:0] char [12:8] kind              char_valid    token_end
//                [28:13] line [30:29] error
//
// A byte is taken every cycle while the two-entry bundle queue has room.
// Each byte yields zero to four results, sent one per output transfer, so
// output bandwidth is set by the serializer: one result per cycle while m_axis_tready is high.
// Synchronous active-low reset returns the scanner to idle, line one.
// Output stalls back up through the queue to s_axis_tready.
// ----------------------------------------------------------------------------
module source_text_lexer_unit
    import stl_pkg::*;
#(
    parameter int LINE_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tuser,   // [0] end_of_input
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // char, kind, line, error, pad
    output logic             m_axis_tuser,   // [0] char_valid
    output logic             m_axis_tlast    // token_end
);

    logic    w_space;
    logic    w_push;
    logic    w_avail;
    logic    w_pop;
    t_bundle w_in_bun;
    t_bundle w_out_bun;
    t_res    w_res;

    stl_front #(.LINE_BITS(LINE_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_eoi    (s_axis_tuser),
        .i_space  (w_space),
        .o_ready  (s_axis_tready),
        .o_push   (w_push),
        .o_bundle (w_in_bun)
    );

    stl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_bun),
        .i_pop   (w_pop),
        .o_space (w_space),
        .o_avail (w_avail),
        .o_data  (w_out_bun)
    );

    stl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_avail),
        .i_data  (w_out_bun),
        .o_pop   (w_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (w_res)
    );

    // Pack the result fields onto the master side.
    assign m_axis_tdata = {1'b0, w_res.err, w_res.line, w_res.kind, w_res.ch};
    assign m_axis_tuser = w_res.cv;
    assign m_axis_tlast = w_res.te;

endmodule
`default_nettype wire

/* hdl/stl_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_front
// Accepts source bytes, runs the scanner state and pushes one bundle of
// results per byte that yields any result.
// ----------------------------------------------------------------------------
module stl_front
    import stl_pkg::*;
#(
    parameter int LINE_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_eoi,
    input  wire logic       i_space,
    output logic            o_ready,
    output logic            o_push,
    output t_bundle         o_bundle
);

    localparam logic [32:0] LINE_LIM = (33'd1 << LINE_BITS) - 33'd1;

    t_scan_st               r_st;
    logic [LINE_BITS-1:0]   r_line;
    t_scan                  n_scan;
    logic [7:0]             w_c;
    logic                   w_accept;

    assign w_c      = i_eoi ? 8'd0 : i_byte;
    assign o_ready  = i_space;
    assign w_accept = i_valid && i_space;

    // Scanner passes for one byte, then the end-of-text wrap-up.
    always_comb begin
        n_scan         = '0;
        n_scan.st      = r_st;
        n_scan.st.line = 32'(r_line);
        for (int i = 0; i < SCAN_STEPS; i++) begin
            if (!n_scan.done) begin
                n_scan = scan_byte(n_scan, w_c, LINE_LIM[31:0]);
            end
        end
        if (w_c == 8'd0) begin
            n_scan    = emit_end(n_scan, K_END, E_NONE);
            n_scan.st = scan_reset();
        end
    end

    assign o_push   = w_accept && (n_scan.out.cnt != 3'd0);
    assign o_bundle = n_scan.out;

    // State update on each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= scan_reset();
            r_line <= LINE_BITS'(1);
        end else if (w_accept) begin
            r_st   <= n_scan.st;
            r_line <= n_scan.st.line[LINE_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

/* hdl/stl_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_fifo
// Two-entry queue of result bundles between the scanner and the output side.
// ----------------------------------------------------------------------------
module stl_fifo
    import stl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  t_bundle      i_data,
    input  wire logic    i_pop,
    output logic         o_space,
    output logic         o_avail,
    output t_bundle      o_data
);

    t_bundle    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_space = r_cnt != 2'd2;
    assign o_avail = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

/* hdl/stl_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_back
// Takes bundles from the queue and sends their results one per transfer.
// ----------------------------------------------------------------------------
module stl_back
    import stl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_avail,
    input  t_bundle      i_data,
    output logic         o_pop,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_res         o_res
);

    t_bundle    r_bun;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       w_last;
    logic       w_load;

    assign w_last  = (3'(r_idx) + 3'd1) == r_bun.cnt;
    assign w_load  = !r_busy || (w_last && i_ready);
    assign o_pop   = w_load && i_avail;
    assign o_valid = r_busy;
    assign o_res   = r_bun.res[r_idx];

    // Result sequencing within the held bundle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (w_load) begin
            r_busy <= i_avail;
            r_idx  <= 2'd0;
        end else if (i_ready) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

    // Bundle register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bun <= i_data;
        end
    end

endmodule
`default_nettype wire
